### design/maze_wall_union_merge_assert.svh
// Assertion macros for the maze wall union merge block.
// Included by modules that check their own sequencing.
`ifndef MAZE_WALL_UNION_MERGE_ASSERT_SVH
`define MAZE_WALL_UNION_MERGE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MWUM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the following cycle.
`define MWUM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/mwum_pkg.sv
// Package for the maze wall union merge block: constants, codes and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mwum_pkg;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int IDX_W   = 12;
  localparam int SETS_W  = 13;
  localparam int CNT_W   = 24;
  localparam int SIZE_W  = 7;
  localparam int WALLS_W = 4;
  localparam logic [CNT_W-1:0] LIMIT_RST = 24'd1000000;
  localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;

  localparam logic [2:0] ST_CLEARED = 3'd0;
  localparam logic [2:0] ST_EDGE    = 3'd1;
  localparam logic [2:0] ST_OPEN    = 3'd2;
  localparam logic [2:0] ST_SAME    = 3'd3;
  localparam logic [2:0] ST_REMOVED = 3'd4;
  localparam logic [2:0] ST_LIMIT   = 3'd5;
  localparam logic [2:0] ST_OUTSIDE = 3'd6;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;
endpackage
`default_nettype wire

### design/maze_wall_union_merge.sv
// Maze wall union merge: randomized Kruskal maze builder on one grid.
// After reset the block runs a clearing pass over every cell, one cell per cycle,
// with in_ready low; the grid then holds closed walls and one label per cell. An
// init request repeats that pass, and its result is valid once the pass ends. An
// attempt first checks the limit and the index (a stray index or an exceeded limit
// ends the attempt with a result), then finds the cell's row by stepping one row
// per cycle. The two cells' walls and labels are then read through the one address
// port of each store. A merge writes both walls back and walks every cell label,
// reading each label then writing it back. The walk over the label store sets the
// rate. One result per request; the input is ready again once that result is taken
// and the sequencer has gone back from S_OUT to S_IDLE.
// Uses mwum_pkg and mwum_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "maze_wall_union_merge_assert.svh"
module maze_wall_union_merge #(
  parameter int MAX_WIDTH  = mwum_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mwum_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_mode,
  input  wire logic [mwum_pkg::IDX_W-1:0]  in_cell_index,
  input  wire logic [1:0]                  in_wall_dir,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [2:0]                  out_status,
  output logic      [mwum_pkg::IDX_W-1:0]  out_neighbor_index,
  output logic      [mwum_pkg::SETS_W-1:0] out_sets_left,
  output logic                             out_done_res,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [23:0]                 cfg_data
);
  import mwum_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW:0] CELLS_C = (AW+1)'(CELLS);
  localparam int RST_W = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam int RST_H = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
  localparam logic [SETS_W-1:0] SETS_RST = SETS_W'(RST_W * RST_H);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLEAR = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_RDA   = 10'b0000001000,
    S_RDB   = 10'b0000010000,
    S_DEC   = 10'b0000100000,
    S_WRB   = 10'b0001000000,
    S_SWRD  = 10'b0010000000,
    S_SWWR  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] width_r, height_r;
  logic [CNT_W-1:0]  limit_r, count_r;
  logic [SETS_W-1:0] sets_r;
  logic              fin_r;
  logic              boot_r;
  logic [IDX_W-1:0]  idx_r, nb_r;
  logic [1:0]        dir_r;
  logic [2:0]        stat_r;
  logic [AW:0]       ptr_r;
  logic [IDX_W-1:0]  lab_a_r, lab_b_r;
  logic [WALLS_W-1:0] wall_a_r, wall_b_r;
  logic [2:0]        rd_r;  // read phase counter in address phases
  logic              ovalid_r;

  // effective sizes: zero acts as one, clamp to maximum
  logic [8:0] w_eff, h_eff;
  always_comb begin
    w_eff = (width_r == '0) ? 9'd1 :
            ({2'b0, width_r} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {2'b0, width_r};
    h_eff = (height_r == '0) ? 9'd1 :
            ({2'b0, height_r} > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {2'b0, height_r};
  end
  logic [17:0] area;
  assign area = w_eff * h_eff;

  // row of the chosen cell, found by stepping one row per cycle in S_CHK
  logic [8:0]  row_r;
  logic [IDX_W:0] rowbase_r;

  logic [IDX_W:0] col;
  assign col = {1'b0, idx_r} - rowbase_r;

  // stores
  logic              wall_we, lab_we;
  logic [AW-1:0]     wall_addr, lab_addr;
  logic [WALLS_W-1:0] wall_wd, wall_rd;
  logic [IDX_W-1:0]  lab_wd, lab_rd;

  mwum_ram #(.WIDTH(WALLS_W), .DEPTH(CELLS)) u_walls (
    .clk(clk), .we(wall_we), .addr(wall_addr), .wdata(wall_wd), .rdata(wall_rd));
  mwum_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_labels (
    .clk(clk), .we(lab_we), .addr(lab_addr), .wdata(lab_wd), .rdata(lab_rd));

  // wall masks, grid edge and neighbour for the chosen direction
  logic [WALLS_W-1:0] mine, theirs;
  logic               on_edge;
  logic [IDX_W-1:0]   nb_calc;
  always_comb begin
    case (dir_r)
      DIR_LEFT: begin
        mine = 4'b0001; theirs = 4'b0010;
        on_edge = (col == '0); nb_calc = idx_r - 1'b1;
      end
      DIR_RIGHT: begin
        mine = 4'b0010; theirs = 4'b0001;
        on_edge = (col == {4'b0, w_eff} - 1'b1); nb_calc = idx_r + 1'b1;
      end
      DIR_UP: begin
        mine = 4'b0100; theirs = 4'b1000;
        on_edge = (row_r == '0); nb_calc = idx_r - IDX_W'(w_eff);
      end
      default: begin
        mine = 4'b1000; theirs = 4'b0100;
        on_edge = (row_r == h_eff - 1'b1); nb_calc = idx_r + IDX_W'(w_eff);
      end
    endcase
  end

  // merge only through a closed wall into a different set
  logic merge_ok;
  assign merge_ok = ((wall_a_r & mine) != '0) && (lab_b_r != lab_a_r);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_status = stat_r;
  assign out_neighbor_index = nb_r;
  assign out_sets_left = sets_r;
  assign out_done_res = fin_r;

  // store port control
  always_comb begin
    wall_we = 1'b0; lab_we = 1'b0;
    wall_addr = ptr_r[AW-1:0]; lab_addr = ptr_r[AW-1:0];
    wall_wd = {WALLS_W{1'b1}}; lab_wd = IDX_W'(ptr_r);
    case (state_r)
      S_CLEAR: begin
        wall_we = 1'b1; lab_we = 1'b1;
      end
      S_RDA, S_CHK: begin
        wall_addr = AW'(idx_r); lab_addr = AW'(idx_r);
      end
      S_RDB: begin
        wall_addr = AW'(nb_r); lab_addr = AW'(nb_r);
      end
      S_DEC: begin
        wall_addr = AW'(idx_r); wall_we = merge_ok; wall_wd = wall_a_r & ~mine;
      end
      S_WRB: begin
        wall_addr = AW'(nb_r); wall_we = 1'b1; wall_wd = wall_b_r & ~theirs;
      end
      S_SWWR: begin
        lab_we = (lab_rd == lab_b_r); lab_wd = lab_a_r;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = in_mode ? S_CHK : S_CLEAR;
      S_CLEAR: if (ptr_r == CELLS_C - 1'b1) state_nxt = boot_r ? S_IDLE : S_OUT;
      S_CHK:   if (rd_r == 3'd7) state_nxt = S_OUT;
               else if (rd_r == 3'd6) state_nxt = S_RDA;
      S_RDA:   state_nxt = S_RDB;
      S_RDB:   if (rd_r == 3'd2) state_nxt = S_DEC;
      S_DEC:   state_nxt = merge_ok ? S_WRB : S_OUT;
      S_WRB:   state_nxt = S_SWRD;
      S_SWRD:  state_nxt = S_SWWR;
      S_SWWR:  if (ptr_r == CELLS_C - 1'b1) state_nxt = S_OUT;
               else state_nxt = S_SWRD;
      S_OUT:   if (!ovalid_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; boot_r <= 1'b1;
      width_r <= 7'd64; height_r <= 7'd64; limit_r <= LIMIT_RST;
      count_r <= '0; sets_r <= SETS_RST; fin_r <= 1'b0; ovalid_r <= 1'b0;
      ptr_r <= '0; rd_r <= '0;
    end else begin
      state_r <= state_nxt;
      // drop result once taken
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
          CFG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
          CFG_LIMIT:  limit_r  <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          idx_r <= in_cell_index; dir_r <= in_wall_dir; nb_r <= '0;
          ptr_r <= '0; rd_r <= '0; row_r <= '0; rowbase_r <= '0;
          if (!in_mode) begin
            stat_r <= ST_CLEARED; count_r <= '0;
            sets_r <= SETS_W'(area);
            fin_r <= (area <= 18'd1);
          end else if (count_r != COUNT_MAX) begin
            count_r <= count_r + 1'b1;
          end
        end
        S_CLEAR: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == CELLS_C - 1'b1) boot_r <= 1'b0;
        end
        S_CHK: begin
          // step-wise checks, one per cycle
          case (rd_r)
            3'd0: begin
              if (count_r > limit_r) begin
                stat_r <= ST_LIMIT; fin_r <= 1'b1; rd_r <= 3'd7;
              end else if ({6'b0, idx_r} >= area) begin
                stat_r <= ST_OUTSIDE; rd_r <= 3'd7;
              end else rd_r <= 3'd1;
            end
            3'd1: begin
              // find row: one row per cycle
              if ({1'b0, idx_r} >= rowbase_r + {4'b0, w_eff}) begin
                rowbase_r <= rowbase_r + {4'b0, w_eff}; row_r <= row_r + 1'b1;
              end else rd_r <= 3'd2;
            end
            3'd2: begin
              // an edge wall reports no neighbour
              if (on_edge) begin
                stat_r <= ST_EDGE; rd_r <= 3'd7;
              end else begin
                nb_r <= nb_calc; rd_r <= 3'd6;
              end
            end
            default: ;
          endcase
        end
        S_RDA: rd_r <= 3'd0;
        S_RDB: begin
          rd_r <= rd_r + 1'b1;
          if (rd_r == 3'd0) begin wall_a_r <= wall_rd; lab_a_r <= lab_rd; end
          if (rd_r == 3'd2) begin wall_b_r <= wall_rd; lab_b_r <= lab_rd; end
        end
        S_DEC: begin
          if ((wall_a_r & mine) == '0) stat_r <= ST_OPEN;
          else if (lab_b_r == lab_a_r) stat_r <= ST_SAME;
          else begin
            stat_r <= ST_REMOVED;
            if (sets_r != '0) sets_r <= sets_r - 1'b1;
            if (sets_r <= 13'd2) fin_r <= 1'b1;
          end
          ptr_r <= '0;
        end
        S_SWWR: ptr_r <= ptr_r + 1'b1;
        S_OUT: ;
        default: ;
      endcase
      if (state_nxt == S_OUT && state_r != S_OUT) ovalid_r <= 1'b1;
    end
  end

  `MWUM_ASSERT(a_busy_not_ready, state_r != S_IDLE, !in_ready && !cfg_ready, "ready while busy")
  `MWUM_ASSERT(a_one_hot, 1'b1, $onehot(state_r), "state not one-hot")
  `MWUM_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid, "result dropped")
  `MWUM_ASSERT(a_idle_no_result, state_r == S_IDLE, !out_valid, "stray result in idle")
endmodule
`default_nettype wire

### design/mwum_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mwum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write; the registered read returns the old contents on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### verif/tb_maze_wall_union_merge.sv
// Testbench for maze_wall_union_merge: directed and random maze requests
// checked against an in-bench scoreboard that tracks walls and set labels.
// Depends on mwum_pkg and the maze_wall_union_merge RTL.
`timescale 1ns / 1ps
module tb_maze_wall_union_merge;
  import mwum_pkg::*;

  localparam int GRID_CELLS  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic [2:0]        status;
    logic [IDX_W-1:0]  neighbour;
    logic [SETS_W-1:0] sets_left;
    logic              done;
  } maze_result_t;

  // Tracks the maze state and the results still owed by the block
  class maze_scoreboard;
    bit [WALLS_W-1:0] walls[GRID_CELLS];
    bit [IDX_W-1:0]   labels[GRID_CELLS];
    int unsigned      width_reg  = 64;
    int unsigned      height_reg = 64;
    int unsigned      limit_reg  = 1000000;
    int unsigned      sets_left;
    int unsigned      attempts;
    bit               finished;
    maze_result_t     owed_q[$];
    int               errors;

    function new();
      clear_grid();
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
    endfunction

    function int unsigned cells_in_use();
      return clamp_size(width_reg, MAX_WIDTH_DEF) * clamp_size(height_reg, MAX_HEIGHT_DEF);
    endfunction

    function void clear_grid();
      for (int c = 0; c < GRID_CELLS; c++) begin
        walls[c]  = 4'hF;
        labels[c] = c[IDX_W-1:0];
      end
      sets_left = cells_in_use();
      attempts  = 0;
      finished  = (sets_left <= 1);
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        CFG_WIDTH:  width_reg  = val[6:0];
        CFG_HEIGHT: height_reg = val[6:0];
        CFG_LIMIT:  limit_reg  = val;
        default: ;
      endcase
    endfunction

    // Apply one accepted request and queue the result it owes
    function void note_request(logic m, logic [IDX_W-1:0] cell_idx, logic [1:0] dir);
      int unsigned  w, h, idx, nb;
      bit           on_edge;
      bit [3:0]     mine, theirs;
      bit [IDX_W-1:0] old_lbl, keep_lbl;
      maze_result_t r;
      nb  = 0;
      idx = cell_idx;
      if (!m) begin
        clear_grid();
        r.status = ST_CLEARED;
      end else begin
        w = clamp_size(width_reg, MAX_WIDTH_DEF);
        h = clamp_size(height_reg, MAX_HEIGHT_DEF);
        if (attempts < COUNT_MAX) attempts++;
        if (attempts > limit_reg) begin
          finished = 1;
          r.status = ST_LIMIT;
        end else if (idx >= w * h) begin
          r.status = ST_OUTSIDE;
        end else begin
          case (dir)
            DIR_LEFT: begin
              on_edge = (idx % w) == 0; nb = idx - 1; mine = 4'd1; theirs = 4'd2;
            end
            DIR_RIGHT: begin
              on_edge = (idx % w) == w - 1; nb = idx + 1; mine = 4'd2; theirs = 4'd1;
            end
            DIR_UP: begin
              on_edge = idx < w; nb = idx - w; mine = 4'd4; theirs = 4'd8;
            end
            default: begin
              on_edge = (idx / w) == h - 1; nb = idx + w; mine = 4'd8; theirs = 4'd4;
            end
          endcase
          if (on_edge) begin
            nb = 0;
            r.status = ST_EDGE;
          end else if ((walls[idx] & mine) == 0) begin
            r.status = ST_OPEN;
          end else if (labels[nb] == labels[idx]) begin
            r.status = ST_SAME;
          end else begin
            old_lbl  = labels[nb];
            keep_lbl = labels[idx];
            walls[idx] &= ~mine;
            walls[nb]  &= ~theirs;
            for (int c = 0; c < GRID_CELLS; c++)
              if (labels[c] == old_lbl) labels[c] = keep_lbl;
            if (sets_left > 0) sets_left--;
            if (sets_left <= 1) finished = 1;
            r.status = ST_REMOVED;
          end
        end
      end
      r.neighbour = nb[IDX_W-1:0];
      r.sets_left = sets_left[SETS_W-1:0];
      r.done      = finished;
      owed_q.push_back(r);
    endfunction

    function void check_result(maze_result_t got);
      maze_result_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result: status %0d", got.status);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.neighbour !== want.neighbour) begin
        $error("neighbor_index: expected %0d, got %0d", want.neighbour, got.neighbour);
        errors++;
      end
      if (got.sets_left !== want.sets_left) begin
        $error("sets_left: expected %0d, got %0d", want.sets_left, got.sets_left);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("done_res: expected %0d, got %0d", want.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_mode = 1'b0;
  logic [IDX_W-1:0]  in_cell_index = '0;
  logic [1:0]        in_wall_dir = DIR_LEFT;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_status;
  logic [IDX_W-1:0]  out_neighbor_index;
  logic [SETS_W-1:0] out_sets_left;
  logic              out_done_res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_WIDTH;
  logic [23:0]       cfg_data = '0;

  maze_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  maze_wall_union_merge DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_cell_index(in_cell_index), .in_wall_dir(in_wall_dir),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_neighbor_index(out_neighbor_index), .out_sets_left(out_sets_left),
    .out_done_res(out_done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Drive the result ready: long hold-off when asked, else random stalls
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_status, out_neighbor_index, out_sets_left, out_done_res});
  end

  // Watchdog: abort after too long without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input logic m, input logic [IDX_W-1:0] cell_idx,
                          input logic [1:0] dir);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_mode       = m;
    in_cell_index = cell_idx;
    in_wall_dir   = dir;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(m, cell_idx, dir);
    @(negedge clk);
  endtask

  // Pause the sender until every owed result has arrived
  task automatic drain();
    in_valid = 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_grid(input int w, input int h, input int lim);
    write_reg(CFG_WIDTH, 24'(w));
    write_reg(CFG_HEIGHT, 24'(h));
    write_reg(CFG_LIMIT, 24'(lim));
  endtask

  // Mostly well-formed attempts inside the grid, some inits and stray cells
  task automatic run_random(input int count);
    int r, cells;
    for (int n = 0; n < count; n++) begin
      r     = $urandom_range(99);
      cells = sb.cells_in_use();
      if (r < 5)
        send_req(1'b0, IDX_W'($urandom), 2'($urandom));
      else if (r < 13 && cells < GRID_CELLS)
        send_req(1'b1, IDX_W'($urandom_range(GRID_CELLS - 1, cells)), 2'($urandom));
      else
        send_req(1'b1, IDX_W'($urandom_range(cells - 1, 0)), 2'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Full grid: edges, open walls, merges, same set
    send_req(1'b0, 0, DIR_LEFT);
    send_req(1'b1, 0, DIR_LEFT);
    send_req(1'b1, 0, DIR_UP);
    send_req(1'b1, 0, DIR_RIGHT);
    send_req(1'b1, 0, DIR_RIGHT);
    send_req(1'b1, 1, DIR_LEFT);
    send_req(1'b1, 64, DIR_UP);
    send_req(1'b1, 1, DIR_DOWN);
    send_req(1'b1, 65, DIR_LEFT);
    send_req(1'b1, 4095, DIR_RIGHT);
    send_req(1'b1, 4095, DIR_DOWN);
    send_req(1'b1, 4095, DIR_UP);
    drain();

    // Zero width, one row, tiny limit: stray cell and limit exceeded
    set_grid(0, 1, 2);
    send_req(1'b0, 4095, DIR_DOWN);
    send_req(1'b1, 0, DIR_DOWN);
    send_req(1'b1, 1, DIR_RIGHT);
    send_req(1'b1, 0, DIR_LEFT);
    drain();

    // Oversized registers clamp to the full grid; largest limit
    set_grid(100, 127, 24'hFFFFFF);
    send_req(1'b0, 0, DIR_LEFT);
    send_req(1'b1, 4032, DIR_UP);
    drain();

    // Random phases under different idle patterns
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      set_grid($urandom_range(6, 2), $urandom_range(6, 2),
               (p == 2) ? 12 : 24'hFFFFFF);
      // Last phase keeps the old grid across a size change
      if (p != 3) send_req(1'b0, 0, DIR_LEFT);
      run_random(28);
      drain();
    end

    // Hold the result side off while cheap requests wait behind the held result
    idle_pct  = 0;
    stall_pct = 0;
    set_grid(4, 4, 24'hFFFFFF);
    send_req(1'b0, 0, DIR_LEFT);
    drain();
    hold_req = 3000;
    for (int n = 0; n < 8; n++)
      send_req(1'b1, IDX_W'((n % 2) ? 20 + n : 0), DIR_LEFT);
    drain();

    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/mwum_pkg.sv
design/mwum_ram.sv
design/maze_wall_union_merge.sv
verif/tb_maze_wall_union_merge.sv
